FILE: src/fcsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_pkg - shared types and constants for the filled circle span generator
// Holds field widths, the sequencer state type, the root unit's widths and its handshake types.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  // payload field widths
  localparam int unsigned CoordW  = 11;
  localparam int unsigned RadiusW = 5;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned SpanXW  = 8;
  localparam int unsigned SpanYW  = 8;
  localparam int unsigned SpanWW  = 6;

  // radicand is r*r - dy*dy, at most 31*31
  localparam int unsigned RadW  = 2 * RadiusW;
  // square root of the radicand fits the radius width
  localparam int unsigned RootW = RadiusW;
  // bit index of the digit-by-digit root
  localparam int unsigned StepW = $clog2(RootW);

  // row sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CLIP,
    ST_SEND
  } fcsg_state_t;

  // handshake between sequencer and root unit
  typedef struct packed {
    logic            start;
    logic [RadW-1:0] value;
  } fcsg_root_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } fcsg_root_rsp_t;

endpackage

FILE: src/fcsg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_if - channel interfaces of the filled circle span generator
// Circle input channel and span output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcsg_circle_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcsg_pkg::CoordW-1:0]  center_x;
  logic signed [fcsg_pkg::CoordW-1:0]  center_y;
  logic        [fcsg_pkg::RadiusW-1:0] radius;
  logic        [fcsg_pkg::ColorW-1:0]  fill_color;

  modport source (output valid, center_x, center_y, radius, fill_color, input ready);
  modport sink   (input valid, center_x, center_y, radius, fill_color, output ready);
endinterface

interface fcsg_span_if;
  logic                               valid;
  logic                               ready;
  logic [fcsg_pkg::SpanXW-1:0]        span_x;
  logic [fcsg_pkg::SpanYW-1:0]        span_y;
  logic [fcsg_pkg::SpanWW-1:0]        span_width;
  logic                               visible;
  logic [fcsg_pkg::ColorW-1:0]        span_color;
  logic                               last;

  modport source (output valid, span_x, span_y, span_width, visible, span_color, last,
                  input ready);
  modport sink   (input valid, span_x, span_y, span_width, visible, span_color, last,
                  output ready);
endinterface

FILE: src/filled_circle_span_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_generator - one clipped span per row of a filled circle
//
//   channel  role    handshake     payload
//   circle   sink    valid/ready   center_x, center_y, radius, fill_color
//   span     source  valid/ready   span_x, span_y, span_width, visible,
//                                  span_color, last
//
// A circle of radius r yields 2*r+1 spans, rows dy = -r .. +r in order.
// Each row passes through a square step, five root steps in the shared root unit,
// a result step, a clip step and a send step, where it waits while the span sink
// holds ready low. circle.ready is high only while no circle is in work.
// Synchronous reset.
// ----------------------------------------------------------------------------
module filled_circle_span_generator #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240,
  parameter int MAX_RADIUS    = 31
) (
  input  logic        clk,
  input  logic        rst,
  fcsg_circle_if.sink circle,
  fcsg_span_if.source span
);

  localparam int unsigned CalcW = 13;
  localparam logic signed [CalcW-1:0] ScrW = CalcW'(SCREEN_WIDTH);
  localparam logic signed [CalcW-1:0] ScrH = CalcW'(SCREEN_HEIGHT);
  localparam logic [fcsg_pkg::RadiusW-1:0] RadMax = fcsg_pkg::RadiusW'(MAX_RADIUS);

  fcsg_pkg::fcsg_state_t state, state_next;

  // circle registers
  logic signed [fcsg_pkg::CoordW-1:0]   cx;
  logic signed [fcsg_pkg::CoordW-1:0]   cy;
  logic        [fcsg_pkg::RadiusW-1:0]  r;
  logic        [fcsg_pkg::ColorW-1:0]   color;
  logic        [fcsg_pkg::RadW-1:0]     rr;
  logic signed [fcsg_pkg::RadiusW:0]    dy;

  // span output register
  logic [fcsg_pkg::SpanXW-1:0] out_x;
  logic [fcsg_pkg::SpanYW-1:0] out_y;
  logic [fcsg_pkg::SpanWW-1:0] out_w;
  logic                        out_vis;
  logic [fcsg_pkg::ColorW-1:0] out_color;
  logic                        out_last;

  fcsg_pkg::fcsg_root_req_t root_req;
  fcsg_pkg::fcsg_root_rsp_t root_rsp;

  logic                          root_start;
  logic                          circle_fire;
  logic                          span_fire;
  logic                          row_last;
  logic [fcsg_pkg::RadiusW-1:0]  r_sat;
  logic [fcsg_pkg::RadiusW-1:0]  dy_abs;
  logic [fcsg_pkg::RadW-1:0]     dy_sq;

  logic signed [CalcW-1:0] x0, y0, w0, x1, w1, w2;
  logic                    vis0, vis1;

  assign circle_fire = circle.valid && circle.ready;
  assign span_fire   = span.valid && span.ready;
  assign row_last    = (dy == $signed({1'b0, r}));

  // saturate radius, magnitude of row offset
  always_comb begin
    r_sat  = (circle.radius > RadMax) ? RadMax : circle.radius;
    dy_abs = dy[fcsg_pkg::RadiusW] ? fcsg_pkg::RadiusW'(-dy) : dy[fcsg_pkg::RadiusW-1:0];
    dy_sq  = fcsg_pkg::RadW'(dy_abs) * fcsg_pkg::RadW'(dy_abs);
  end

  // radicand r*r - dy*dy goes to the root unit
  assign root_req = {root_start, rr - dy_sq};

  fcsg_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  // span endpoints and clipping against the screen
  always_comb begin
    x0   = CalcW'(cx) - CalcW'({1'b0, root_rsp.root});
    y0   = CalcW'(cy) + CalcW'(dy);
    w0   = CalcW'({1'b0, root_rsp.root, 1'b1});
    vis0 = !((y0 < 0) || (y0 >= ScrH) || (x0 >= ScrW));
    if (x0 < 0) begin
      x1 = '0;
      w1 = w0 + x0;
    end else begin
      x1 = x0;
      w1 = w0;
    end
    vis1 = vis0 && (w1 > 0);
    w2   = ((x1 + w1) > ScrW) ? (ScrW - x1) : w1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fcsg_pkg::ST_IDLE:   if (circle_fire) state_next = fcsg_pkg::ST_SQUARE;
      fcsg_pkg::ST_SQUARE: state_next = fcsg_pkg::ST_ROOT;
      fcsg_pkg::ST_ROOT:   if (root_rsp.done) state_next = fcsg_pkg::ST_CLIP;
      fcsg_pkg::ST_CLIP:   state_next = fcsg_pkg::ST_SEND;
      fcsg_pkg::ST_SEND: begin
        if (span_fire) begin
          state_next = row_last ? fcsg_pkg::ST_IDLE : fcsg_pkg::ST_SQUARE;
        end
      end
      default:             state_next = fcsg_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    circle.ready = 1'b0;
    span.valid   = 1'b0;
    root_start   = 1'b0;
    case (state)
      fcsg_pkg::ST_IDLE:   circle.ready = 1'b1;
      fcsg_pkg::ST_SQUARE: root_start   = 1'b1;
      fcsg_pkg::ST_SEND:   span.valid   = 1'b1;
      default: begin
        circle.ready = 1'b0;
        span.valid   = 1'b0;
        root_start   = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // circle capture and row stepping
  always_ff @(posedge clk) begin
    if (circle_fire) begin
      cx    <= circle.center_x;
      cy    <= circle.center_y;
      color <= circle.fill_color;
      r     <= r_sat;
      rr    <= fcsg_pkg::RadW'(r_sat) * fcsg_pkg::RadW'(r_sat);
      dy    <= -$signed({1'b0, r_sat});
    end else if (span_fire && !row_last) begin
      dy <= dy + (fcsg_pkg::RadiusW + 1)'(1);
    end
  end

  // span output register
  always_ff @(posedge clk) begin
    if (state == fcsg_pkg::ST_CLIP) begin
      out_last <= row_last;
      out_vis  <= vis1;
      if (vis1) begin
        out_x     <= x1[fcsg_pkg::SpanXW-1:0];
        out_y     <= y0[fcsg_pkg::SpanYW-1:0];
        out_w     <= w2[fcsg_pkg::SpanWW-1:0];
        out_color <= color;
      end else begin
        out_x     <= '0;
        out_y     <= '0;
        out_w     <= '0;
        out_color <= '0;
      end
    end
  end

  assign span.span_x     = out_x;
  assign span.span_y     = out_y;
  assign span.span_width = out_w;
  assign span.visible    = out_vis;
  assign span.span_color = out_color;
  assign span.last       = out_last;

endmodule

FILE: src/fcsg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_sqrt - iterative floor square root
// Digit-by-digit root, one result bit per cycle from the top bit down, using
// one small squaring multiplier and a compare.
// ----------------------------------------------------------------------------
module fcsg_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  fcsg_pkg::fcsg_root_req_t req,
  output fcsg_pkg::fcsg_root_rsp_t rsp
);

  logic                               busy;
  logic [fcsg_pkg::StepW-1:0]         step;
  logic [fcsg_pkg::RadW-1:0]          value;
  logic [fcsg_pkg::RootW-1:0]         root;
  logic                               done;

  logic [fcsg_pkg::RootW-1:0]         trial;
  logic [fcsg_pkg::RadW-1:0]          trial_sq;

  // trial root with the current bit set, and its square
  always_comb begin
    trial    = root | (fcsg_pkg::RootW'(1) << step);
    trial_sq = fcsg_pkg::RadW'(trial) * fcsg_pkg::RadW'(trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == '0);
      if (req.start) begin
        busy <= 1'b1;
        step <= fcsg_pkg::StepW'(fcsg_pkg::RootW - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      value <= req.value;
      root  <= '0;
    end else if (busy && (trial_sq <= value)) begin
      root <= trial;
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

FILE: sim/fcsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_checker - span predictor and scoreboard for the circle span generator
// Watches both channels. Every accepted circle is expanded into its list of
// clipped row spans. Every accepted span is compared field by field against
// the oldest span still expected.
// ----------------------------------------------------------------------------
module fcsg_checker #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240,
  parameter int MAX_RADIUS    = 31
) (
  input  logic   clk,
  input  logic   rst,
  fcsg_circle_if circle,
  fcsg_span_if   span,
  output int     errors,
  output int     pending
);

  typedef struct packed {
    logic [fcsg_pkg::SpanXW-1:0] x;
    logic [fcsg_pkg::SpanYW-1:0] y;
    logic [fcsg_pkg::SpanWW-1:0] width;
    logic                        visible;
    logic [fcsg_pkg::ColorW-1:0] color;
    logic                        last;
  } span_t;

  span_t expected_spans[$];
  int    mismatch_count = 0;

  // largest root whose square fits in the radicand, zero for empty rows
  function automatic int half_width(input int radicand);
    int root;
    root = MAX_RADIUS;
    while (root > 0 && root * root > radicand) root--;
    return root;
  endfunction

  // expand one circle into its rows, top to bottom, clipped to the screen
  function automatic void predict_circle_spans(
      input logic signed [fcsg_pkg::CoordW-1:0] cx_in,
      input logic signed [fcsg_pkg::CoordW-1:0] cy_in,
      input logic [fcsg_pkg::RadiusW-1:0]       r_in,
      input logic [fcsg_pkg::ColorW-1:0]        color);
    int    cx;
    int    cy;
    int    r;
    int    dy;
    int    dx;
    int    x;
    int    y;
    int    w;
    logic  vis;
    span_t s;
    cx = cx_in;
    cy = cy_in;
    r  = r_in;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    for (dy = -r; dy <= r; dy++) begin
      dx  = half_width(r * r - dy * dy);
      x   = cx - dx;
      y   = cy + dy;
      w   = 2 * dx + 1;
      vis = !(y < 0 || y >= SCREEN_HEIGHT || x >= SCREEN_WIDTH);
      // left clip eats into the width
      if (vis && x < 0) begin
        w = w + x;
        x = 0;
      end
      if (vis && w <= 0) vis = 1'b0;
      // right clip
      if (vis && x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - x;
      s = '0;
      if (vis) begin
        s.x       = x[fcsg_pkg::SpanXW-1:0];
        s.y       = y[fcsg_pkg::SpanYW-1:0];
        s.width   = w[fcsg_pkg::SpanWW-1:0];
        s.visible = 1'b1;
        s.color   = color;
      end
      s.last = (dy == r);
      expected_spans.push_back(s);
    end
  endfunction

  // compare one span transaction with the oldest expected span
  task automatic check_span_transaction();
    span_t exp_s;
    if (expected_spans.size() == 0) begin
      $error("span transaction with no span expected: x=%0d y=%0d width=%0d visible=%0b",
             span.span_x, span.span_y, span.span_width, span.visible);
      mismatch_count++;
    end else begin
      exp_s = expected_spans.pop_front();
      if (span.span_x !== exp_s.x) begin
        $error("span_x: expected %0d, actual %0d", exp_s.x, span.span_x);
        mismatch_count++;
      end
      if (span.span_y !== exp_s.y) begin
        $error("span_y: expected %0d, actual %0d", exp_s.y, span.span_y);
        mismatch_count++;
      end
      if (span.span_width !== exp_s.width) begin
        $error("span_width: expected %0d, actual %0d", exp_s.width, span.span_width);
        mismatch_count++;
      end
      if (span.visible !== exp_s.visible) begin
        $error("visible: expected %0b, actual %0b", exp_s.visible, span.visible);
        mismatch_count++;
      end
      if (span.span_color !== exp_s.color) begin
        $error("span_color: expected 0x%04h, actual 0x%04h", exp_s.color, span.span_color);
        mismatch_count++;
      end
      if (span.last !== exp_s.last) begin
        $error("last: expected %0b, actual %0b", exp_s.last, span.last);
        mismatch_count++;
      end
    end
  endtask

  // sample both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      expected_spans.delete();
    end else begin
      if (circle.valid && circle.ready)
        predict_circle_spans(circle.center_x, circle.center_y, circle.radius,
                             circle.fill_color);
      if (span.valid && span.ready) check_span_transaction();
    end
    pending <= expected_spans.size();
    errors  <= mismatch_count;
  end

endmodule

FILE: sim/tb_filled_circle_span_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_filled_circle_span_generator - testbench top for the circle span generator
// Drives directed edge and clipping circles, then random circles, with random
// gaps on the circle side and random stalls on the span side, including one
// long stall that backs the block up. Checking is done in fcsg_checker.
// ----------------------------------------------------------------------------
module tb_filled_circle_span_generator;

  localparam int ScreenW       = 240;
  localparam int ScreenH       = 240;
  localparam int MaxRadius     = 31;
  localparam int RandomCircles = 240;
  localparam int WatchdogLimit = 4000;
  localparam int LongHold      = 400;
  localparam int LongHoldAt    = 3000;
  localparam int DrainCycles   = 30;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cycles;

  fcsg_circle_if circle ();
  fcsg_span_if   span ();

  filled_circle_span_generator #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH),
    .MAX_RADIUS   (MaxRadius)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .circle(circle),
    .span  (span)
  );

  fcsg_checker #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH),
    .MAX_RADIUS   (MaxRadius)
  ) u_checker (
    .clk    (clk),
    .rst    (rst),
    .circle (circle),
    .span   (span),
    .errors (errors),
    .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle cycles before the next circle: mostly none, some short, a few long
  function automatic int next_gap();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 0;
    if (sel < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // coordinate near the screen most of the time, anywhere in range otherwise
  function automatic int pick_coord(input int extent);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return int'($urandom_range(0, extent + 80)) - 40;
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // mostly small circles, some of any size, a few near the largest
  function automatic int pick_radius();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 6);
    if (sel < 8) return $urandom_range(0, 31);
    return $urandom_range(26, 31);
  endfunction

  // offer one circle and hold it until the block takes it; valid stays high after
  task automatic send_circle(input int cx, input int cy, input int r, input int color,
                             input int gap);
    if (gap > 0) begin
      circle.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    circle.valid      <= 1'b1;
    circle.center_x   <= cx[fcsg_pkg::CoordW-1:0];
    circle.center_y   <= cy[fcsg_pkg::CoordW-1:0];
    circle.radius     <= r[fcsg_pkg::RadiusW-1:0];
    circle.fill_color <= color[fcsg_pkg::ColorW-1:0];
    @(posedge clk);
    while (!circle.ready) @(posedge clk);
  endtask

  // circle stimulus and verdict
  initial begin
    int n;
    rst               = 1'b1;
    circle.valid      = 1'b0;
    circle.center_x   = '0;
    circle.center_y   = '0;
    circle.radius     = '0;
    circle.fill_color = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: radius extremes, clipping on every edge, far off screen
    send_circle( 120,   120,  0, 16'hFFFF, next_gap());
    send_circle( 120,   120,  1, 16'h0000, next_gap());
    send_circle( 120,   120, 31, 16'hAAAA, next_gap());
    send_circle(   0,     0, 31, 16'h5555, next_gap());
    send_circle( 239,   239, 31, 16'hF800, next_gap());
    send_circle( -31,   100, 31, 16'h07E0, next_gap());
    send_circle( -32,   100, 31, 16'h001F, next_gap());
    send_circle( 270,   100, 31, 16'h1234, next_gap());
    send_circle( 271,   100, 31, 16'hFEDC, next_gap());
    send_circle( 100,   -10, 10, 16'h8001, next_gap());
    send_circle( 100,   249, 10, 16'h7FFE, next_gap());
    send_circle( 100,   250, 10, 16'hC3C3, next_gap());
    send_circle(-1024, -1024, 31, 16'hFFFF, next_gap());
    send_circle(1023,  1023, 31, 16'hFFFF, next_gap());
    send_circle(-1024,  1023,  5, 16'h0F0F, next_gap());
    send_circle(1023, -1024,  5, 16'hF0F0, next_gap());
    send_circle(   0,   120,  0, 16'h3C3C, next_gap());
    send_circle( 239,     0,  0, 16'h00FF, next_gap());
    send_circle(  -1,   120,  0, 16'hFF00, next_gap());
    send_circle( 240,   120,  0, 16'hFFFF, next_gap());
    send_circle( 120,   239,  2, 16'h4321, next_gap());
    send_circle(   5,     5, 31, 16'h9999, next_gap());

    // random circles
    for (n = 0; n < RandomCircles; n++)
      send_circle(pick_coord(ScreenW), pick_coord(ScreenH), pick_radius(),
                  $urandom_range(0, 16'hFFFF), next_gap());
    circle.valid <= 1'b0;

    // drain the expected spans, then let the block settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // span receiver: random stalls, stall-free stretches and one long hold
  initial begin
    int  hold;
    int  mode;
    int  rx_cycles;
    bit  held;
    rx_cycles  = 0;
    held       = 1'b0;
    span.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      if (!held && rx_cycles >= LongHoldAt) begin
        span.ready <= 1'b0;
        hold = LongHold;
        held = 1'b1;
      end else if (mode < 2) begin
        span.ready <= 1'b1;
        hold = $urandom_range(50, 150);
      end else if (mode < 7) begin
        span.ready <= 1'b1;
        hold = $urandom_range(1, 8);
      end else if (mode < 9) begin
        span.ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        span.ready <= 1'b0;
        hold = $urandom_range(10, 40);
      end
      repeat (hold) @(posedge clk);
      rx_cycles += hold;
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (circle.valid && circle.ready) || (span.valid && span.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
